FILE: rtl/lffcl_pkg.sv
// LED frame fade / current limiter package: frame geometry, reset values,
// register indexes and the word types of both channels. No dependencies.
package lffcl_pkg;

  localparam int COLUMNS    = 11;
  localparam int ROWS       = 10;
  localparam int INDICATORS = 4;
  localparam int GRID_LEDS  = COLUMNS * ROWS;
  localparam int FRAME_LEDS = GRID_LEDS + INDICATORS;

  localparam int POS_W = $clog2(FRAME_LEDS);
  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS + 1);

  localparam logic [7:0]  BRIGHTNESS_RESET = 8'd128;
  localparam logic [15:0] LIMIT_RESET      = 16'd9999;

  // Multiply-and-shift reciprocal of 255, exact for any 16-bit dividend.
  localparam logic [16:0] RECIP_255 = 17'd32897;
  localparam int          SHIFT_255 = 23;

  localparam logic [8:0] BLEND_MAX = 9'd256;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic REG_BRIGHTNESS    = 1'b0;
  localparam logic REG_CURRENT_LIMIT = 1'b1;

  typedef struct packed {
    logic [23:0] target_color;
    logic [8:0]  blend_factor;
  } pix_word_t;

  typedef struct packed {
    logic [15:0] pixel_rgb565;
    logic [23:0] filtered_color;
    logic [3:0]  column;
    logic [3:0]  row;
    logic        frame_end;
    logic        over_limit;
    logic [7:0]  drive_brightness;
    logic [15:0] frame_current;
  } res_word_t;

endpackage

FILE: rtl/led_frame_fade_current_limiter_top.sv
// LED frame fade with current limiter, top level and only module.
// Depends on lffcl_pkg for geometry, word types and constants.

// Each accepted word carries the target color of the next LED in scan order
// (grid column by column, top to bottom, then the indicator LEDs). The LED's
// stored color steps toward the target by blend_factor/256 per channel,
// truncated toward zero, and one result word returns the new color (24-bit
// and RGB565) with the LED position. The block also accumulates an estimated
// LED current, saturating at 65535; on the last LED of the frame it reports
// the total and, if it is above current_limit, the reduced brightness
// brightness*limit/total, which becomes the applied brightness. All
// arithmetic runs through one shared 17x17 signed multiplier stepped by a
// sequencer: each word goes through three blend passes, three passes for
// the current estimate, one accumulate and one output load, and the next
// word can be taken in the cycle after its result is loaded. On the frame's
// last LED it takes one more multiply and, when over the limit, a
// one-bit-per-cycle restoring divider for the 8-bit quotient.
// pix_stall stays high until the current word is handed to the result
// register; a finished result waiting on res_stall does not block the next
// word from being accepted. The color store comes up all black after reset
// through per-LED valid bits, so no clearing pass is needed. Writing
// brightness also sets the applied brightness; write registers only while
// idle.
module led_frame_fade_current_limiter_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pix_valid,
  output logic                 pix_stall,
  input  lffcl_pkg::pix_word_t pix,
  output logic                 res_valid,
  input  logic                 res_stall,
  output lffcl_pkg::res_word_t res,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b00000000001,
    ST_BLEND_R = 11'b00000000010,
    ST_BLEND_G = 11'b00000000100,
    ST_BLEND_B = 11'b00000001000,
    ST_CUR_E   = 11'b00000010000,
    ST_CUR_B   = 11'b00000100000,
    ST_CUR_D   = 11'b00001000000,
    ST_SUM     = 11'b00010000000,
    ST_LIM     = 11'b00100000000,
    ST_DIV     = 11'b01000000000,
    ST_DONE    = 11'b10000000000
  } state_t;

  state_t state;

  // Configuration and frame state
  logic [7:0]  brightness;
  logic [15:0] current_limit;
  logic [7:0]  applied_brightness;
  logic [15:0] current_sum;
  logic [lffcl_pkg::POS_W-1:0] pos;
  logic [lffcl_pkg::COL_W-1:0] col;
  logic [lffcl_pkg::ROW_W-1:0] row;

  // Color store with per-LED valid bits
  logic [23:0] colors [lffcl_pkg::FRAME_LEDS];
  logic [lffcl_pkg::FRAME_LEDS-1:0] lit;
  logic [23:0] rd_color;
  logic        rd_lit;

  // Working registers
  logic [23:0] target;
  logic [8:0]  blend;
  logic [23:0] filt;
  logic [5:0]  est;
  logic [13:0] scaled;
  logic [5:0]  led_cur;
  logic [15:0] sum;
  logic        over;
  logic [15:0] rem;
  logic [7:0]  qsh;
  logic [2:0]  div_cnt;

  logic        last;
  logic        pix_take;
  logic        res_free;
  logic        cfg_write;
  logic [23:0] cur_color;
  logic [7:0]  cur_ch;
  logic [7:0]  tgt_ch;
  logic [7:0]  new_ch;
  logic signed [16:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [33:0] prod;
  logic signed [33:0] prod_adj;
  logic signed [33:0] step;
  logic [9:0]  chan_sum;
  logic [16:0] sum_wide;
  logic [16:0] div_try;
  logic [16:0] div_sub;
  logic        div_ge;

  assign pready    = 1'b1;
  assign pix_stall = (state != ST_IDLE);
  assign pix_take  = pix_valid && !pix_stall;
  assign res_free  = !res_valid || !res_stall;
  assign cfg_write = psel && penable && pwrite && pready;
  assign last      = (pos == lffcl_pkg::POS_W'(lffcl_pkg::FRAME_LEDS - 1));
  assign cur_color = rd_lit ? rd_color : 24'd0;

  always_comb begin
    case (paddr[2])
      lffcl_pkg::REG_BRIGHTNESS:    prdata = {24'd0, brightness};
      lffcl_pkg::REG_CURRENT_LIMIT: prdata = {16'd0, current_limit};
      default:                      prdata = 32'd0;
    endcase
  end

  // Channel under blend this cycle
  always_comb begin
    case (state)
      ST_BLEND_R: begin
        cur_ch = cur_color[23:16];
        tgt_ch = target[23:16];
      end
      ST_BLEND_G: begin
        cur_ch = cur_color[15:8];
        tgt_ch = target[15:8];
      end
      default: begin
        cur_ch = cur_color[7:0];
        tgt_ch = target[7:0];
      end
    endcase
  end

  assign chan_sum = {2'd0, filt[23:16]} + {2'd0, filt[15:8]} + {2'd0, filt[7:0]};

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_BLEND_R, ST_BLEND_G, ST_BLEND_B: begin
        mul_a = signed'({8'd0, blend});
        mul_b = signed'(17'({1'b0, tgt_ch}) - 17'({1'b0, cur_ch}));
      end
      ST_CUR_E: begin
        // 20*s = 16*s + 4*s
        mul_a = signed'(17'({chan_sum, 4'd0}) + 17'({chan_sum, 2'd0}));
        mul_b = signed'(lffcl_pkg::RECIP_255);
      end
      ST_CUR_B: begin
        mul_a = signed'({11'd0, est});
        mul_b = signed'({9'd0, brightness});
      end
      ST_CUR_D: begin
        mul_a = signed'({3'd0, scaled});
        mul_b = signed'(lffcl_pkg::RECIP_255);
      end
      ST_LIM: begin
        mul_a = signed'({9'd0, brightness});
        mul_b = signed'({1'b0, current_limit});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  // Truncate toward zero: bias negative products before the arithmetic shift
  assign prod_adj = prod + (prod[33] ? 34'sd255 : 34'sd0);
  assign step     = prod_adj >>> 8;
  assign new_ch   = cur_ch + step[7:0];

  assign sum_wide = {1'b0, current_sum} + {11'd0, led_cur};

  assign div_try = {rem, qsh[7]};
  assign div_ge  = (div_try >= {1'b0, sum});
  assign div_sub = div_try - {1'b0, sum};

  // Color store: read on accept, write back when the result is loaded
  always_ff @(posedge clk) begin
    if (pix_take) begin
      rd_color <= colors[pos];
    end
    if (state == ST_DONE && res_free) begin
      colors[pos] <= filt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      brightness         <= lffcl_pkg::BRIGHTNESS_RESET;
      current_limit      <= lffcl_pkg::LIMIT_RESET;
      applied_brightness <= lffcl_pkg::BRIGHTNESS_RESET;
      current_sum        <= 16'd0;
      pos                <= '0;
      col                <= '0;
      row                <= '0;
      lit                <= '0;
      rd_lit             <= 1'b0;
      res_valid          <= 1'b0;
    end else begin
      // Load a finished word when the output register is free, else drop it once taken
      if (state == ST_DONE && res_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end

      if (cfg_write) begin
        case (paddr[2])
          lffcl_pkg::REG_BRIGHTNESS: begin
            brightness         <= pwdata[7:0];
            applied_brightness <= pwdata[7:0];
          end
          lffcl_pkg::REG_CURRENT_LIMIT: begin
            current_limit <= pwdata[15:0];
          end
          default: begin
            current_limit <= current_limit;
          end
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (pix_take) begin
            target <= pix.target_color;
            blend  <= (pix.blend_factor > lffcl_pkg::BLEND_MAX) ?
                      lffcl_pkg::BLEND_MAX : pix.blend_factor;
            rd_lit <= lit[pos];
            state  <= ST_BLEND_R;
          end
        end
        ST_BLEND_R: begin
          filt[23:16] <= new_ch;
          state       <= ST_BLEND_G;
        end
        ST_BLEND_G: begin
          filt[15:8] <= new_ch;
          state      <= ST_BLEND_B;
        end
        ST_BLEND_B: begin
          filt[7:0] <= new_ch;
          state     <= ST_CUR_E;
        end
        ST_CUR_E: begin
          est   <= prod[lffcl_pkg::SHIFT_255+5:lffcl_pkg::SHIFT_255];
          state <= ST_CUR_B;
        end
        ST_CUR_B: begin
          scaled <= prod[13:0];
          state  <= ST_CUR_D;
        end
        ST_CUR_D: begin
          led_cur <= prod[lffcl_pkg::SHIFT_255+5:lffcl_pkg::SHIFT_255];
          state   <= ST_SUM;
        end
        ST_SUM: begin
          // Saturate the running total at full scale
          sum   <= sum_wide[16] ? 16'hFFFF : sum_wide[15:0];
          over  <= 1'b0;
          state <= last ? ST_LIM : ST_DONE;
        end
        ST_LIM: begin
          // Quotient fits 8 bits, so the top 16 bits already sit below sum
          rem     <= prod[23:8];
          qsh     <= prod[7:0];
          div_cnt <= 3'd0;
          over    <= (sum > current_limit);
          state   <= (sum > current_limit) ? ST_DIV : ST_DONE;
        end
        ST_DIV: begin
          rem     <= div_ge ? div_sub[15:0] : div_try[15:0];
          qsh     <= {qsh[6:0], div_ge};
          div_cnt <= div_cnt + 3'd1;
          if (div_cnt == 3'd7) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_free) begin
            res.pixel_rgb565         <= {filt[23:19], filt[15:10], filt[7:3]};
            res.filtered_color       <= filt;
            res.column               <= 4'(col);
            res.row                  <= 4'(row);
            res.frame_end            <= last;
            res.over_limit           <= last && over;
            res.drive_brightness     <= !last ? 8'd0 : (over ? qsh : applied_brightness);
            res.frame_current        <= last ? sum : 16'd0;
            lit[pos]                 <= 1'b1;
            if (last) begin
              if (over) begin
                applied_brightness <= qsh;
              end
              current_sum <= 16'd0;
              pos         <= '0;
              col         <= '0;
              row         <= '0;
            end else begin
              current_sum <= sum;
              pos         <= pos + 1'b1;
              if (pos == lffcl_pkg::POS_W'(lffcl_pkg::GRID_LEDS - 1)) begin
                // Advance into the indicator row, rightmost column first
                col <= lffcl_pkg::COL_W'(lffcl_pkg::COLUMNS - 1);
                row <= lffcl_pkg::ROW_W'(lffcl_pkg::ROWS);
              end else if (pos >= lffcl_pkg::POS_W'(lffcl_pkg::GRID_LEDS)) begin
                col <= col - 1'b1;
              end else if (row == lffcl_pkg::ROW_W'(lffcl_pkg::ROWS - 1)) begin
                row <= '0;
                col <= col + 1'b1;
              end else begin
                row <= row + 1'b1;
              end
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: dv/led_frame_fade_current_limiter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for led_frame_fade_current_limiter_top: a fade and
// current model predicts every result word. Depends on lffcl_pkg and the RTL.
module testbench;
  import lffcl_pkg::*;

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        pix_valid = 1'b0;
  logic        pix_stall;
  pix_word_t   pix     = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  res_word_t   res;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  led_frame_fade_current_limiter_top u_top (.*);

  always #1 clk = ~clk;

  // Fade and current model state: one stored color per LED, the scan
  // pointer, the running frame current and both registers.
  logic [23:0] led_colors [FRAME_LEDS] = '{default: '0};
  int unsigned scan_pos    = 0;
  int unsigned run_current = 0;
  int unsigned applied_bri = 128;
  int unsigned bri_reg     = 128;
  int unsigned limit_reg   = 9999;

  pix_word_t   pending_targets [$];  // words waiting to be driven
  res_word_t   expected_leds [$];    // predicted result words, oldest first
  int unsigned mismatches  = 0;
  bit          calm        = 1'b0;   // suppress all idling on both sides
  int unsigned feed_gap    = 0;
  int unsigned drain_stall = 0;

  // Gap length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Advance the model by one LED and build the result word it produces.
  function automatic res_word_t fade_led(pix_word_t w);
    res_word_t   r;
    logic [23:0] old_c;
    logic [23:0] new_c;
    int          f;
    int          d;
    int          step;
    int unsigned pos;
    int unsigned chan_sum;
    int unsigned led_ma;
    // Blend factors above full scale jump straight to the target.
    f = (w.blend_factor > BLEND_MAX) ? int'(BLEND_MAX) : int'(w.blend_factor);
    if (scan_pos >= FRAME_LEDS) scan_pos = 0;
    pos   = scan_pos;
    old_c = led_colors[pos];
    new_c = '0;
    for (int k = 0; k < 3; k++) begin
      // Signed step, truncated toward zero in both directions.
      d    = int'(w.target_color[8*k +: 8]) - int'(old_c[8*k +: 8]);
      step = (f * d) / 256;
      new_c[8*k +: 8] = 8'(int'(old_c[8*k +: 8]) + step);
    end
    led_colors[pos] = new_c;

    r = '0;
    r.pixel_rgb565   = {new_c[23:19], new_c[15:10], new_c[7:3]};
    r.filtered_color = new_c;
    if (pos < GRID_LEDS) begin
      r.column = 4'(pos / ROWS);
      r.row    = 4'(pos % ROWS);
    end else begin
      // Indicators run right to left along the row below the grid.
      r.column = 4'(COLUMNS - 1 - (pos - GRID_LEDS));
      r.row    = 4'(ROWS);
    end

    chan_sum = int'(new_c[23:16]) + int'(new_c[15:8]) + int'(new_c[7:0]);
    led_ma   = (((20 * chan_sum) / 255) * bri_reg) / 255;
    run_current = run_current + led_ma;
    if (run_current > 65535) run_current = 65535;

    if (pos == FRAME_LEDS - 1) begin
      r.frame_end = 1'b1;
      if (run_current > limit_reg) begin
        applied_bri  = ((bri_reg * limit_reg) / run_current) & 8'hFF;
        r.over_limit = 1'b1;
      end
      r.drive_brightness = applied_bri[7:0];
      r.frame_current    = run_current[15:0];
      scan_pos    = 0;
      run_current = 0;
    end else begin
      scan_pos = pos + 1;
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic pix_word_t random_word();
    pix_word_t   w;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) w.target_color = 24'h000000;
    else if (r < 12) w.target_color = 24'hFFFFFF;
    else w.target_color = 24'($urandom);
    r = $urandom_range(99);
    if (r < 15) w.blend_factor = BLEND_MAX;
    else if (r < 25) w.blend_factor = 9'($urandom_range(511, 257));
    else if (r < 33) w.blend_factor = '0;
    else w.blend_factor = 9'($urandom_range(255, 1));
    return w;
  endfunction

  task automatic queue_target(logic [23:0] color, logic [8:0] blend);
    pix_word_t w;
    w.target_color = color;
    w.blend_factor = blend;
    pending_targets.push_back(w);
  endtask

  // Driver: predict on every accepted word, then present the next one once
  // the slot is free, holding valid low for the chosen gap in between.
  always @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else begin
      if (pix_valid && !pix_stall) expected_leds.push_back(fade_led(pix));
      if (!pix_valid || !pix_stall) begin
        if (feed_gap != 0) begin
          feed_gap--;
          pix_valid <= 1'b0;
        end else if (pending_targets.size() != 0) begin
          pix       <= pending_targets.pop_front();
          pix_valid <= 1'b1;
          feed_gap  = pick_gap();
        end else begin
          pix_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction and
  // throttle the result channel with random stall bursts.
  always @(posedge clk) begin : result_check
    res_word_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_leds.size() == 0) begin
          $error("result word with no prediction pending: 0x%0h", res);
          mismatches++;
        end else begin
          want = expected_leds.pop_front();
          check_field("pixel_rgb565", want.pixel_rgb565, res.pixel_rgb565);
          check_field("filtered_color", want.filtered_color, res.filtered_color);
          check_field("column", want.column, res.column);
          check_field("row", want.row, res.row);
          check_field("frame_end", want.frame_end, res.frame_end);
          check_field("over_limit", want.over_limit, res.over_limit);
          check_field("drive_brightness", want.drive_brightness, res.drive_brightness);
          check_field("frame_current", want.frame_current, res.frame_current);
        end
      end
      if (drain_stall != 0) begin
        res_stall <= 1'b1;
        drain_stall--;
      end else begin
        drain_stall = pick_gap();
        res_stall <= (drain_stall != 0);
        if (drain_stall != 0) drain_stall--;
      end
    end
  end

  // Configuration port: setup cycle, then access until pready.
  task automatic apb_write(logic idx, logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(logic idx, output logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data    = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a register, mirror it into the model and read it back.
  task automatic program_reg(logic idx, int unsigned val);
    logic [31:0] got;
    apb_write(idx, val);
    if (idx == REG_BRIGHTNESS) begin
      bri_reg     = val & 8'hFF;
      applied_bri = bri_reg;
      apb_read(idx, got);
      check_field("brightness readback", bri_reg, got);
    end else begin
      limit_reg = val & 16'hFFFF;
      apb_read(idx, got);
      check_field("current_limit readback", limit_reg, got);
    end
  endtask

  // Hold until no word is queued or on the bus and every result has come.
  // Sample on the falling edge so the driver's and monitor's updates have
  // settled.
  task automatic wait_idle();
    while (pending_targets.size() != 0 || pix_valid || expected_leds.size() != 0)
      @(negedge clk);
  endtask

  initial begin : stimulus
    logic [31:0] got;
    int unsigned b;
    int unsigned l;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers must come up at their reset values.
    apb_read(REG_BRIGHTNESS, got);
    check_field("brightness after reset", 128, got);
    apb_read(REG_CURRENT_LIMIT, got);
    check_field("current_limit after reset", 9999, got);

    // Directed words on a freshly cleared store: full jumps, no movement,
    // steps that truncate to zero, saturated blend factors, single channels
    // and colors that sit right on the RGB565 bit boundaries.
    queue_target(24'h000000, 9'd256);
    queue_target(24'hFFFFFF, 9'd256);
    queue_target(24'hFFFFFF, 9'd0);
    queue_target(24'hFFFFFF, 9'd1);
    queue_target(24'hFFFFFF, 9'd255);
    queue_target(24'hFFFFFF, 9'd511);
    queue_target(24'hFF0000, 9'd257);
    queue_target(24'h00FF00, 9'd384);
    queue_target(24'h0000FF, 9'd128);
    queue_target(24'h808080, 9'd129);
    queue_target(24'h010101, 9'd256);
    queue_target(24'h010101, 9'd255);
    queue_target(24'hF8FCF8, 9'd256);
    queue_target(24'h070307, 9'd256);
    queue_target(24'h123456, 9'd200);
    queue_target(24'hFEDCBA, 9'd100);
    queue_target(24'h7F7F7F, 9'd256);
    queue_target(24'hAAAAAA, 9'd2);
    queue_target(24'h555555, 9'd258);
    queue_target(24'hFFFFFF, 9'd256);

    // Phases of about two frames each. Every boundary drains the block
    // before the registers change, so the sender pauses for all results.
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      case (p)
        0: begin b = 255; l = 0;     end  // every lit frame goes over
        1: begin b = 0;   l = 0;     end  // dark frames, zero current
        2: begin b = 255; l = 65535; end  // never over the limit
        3: begin b = 200; l = 3000;  end  // near the typical frame current
        4: begin b = 1;   l = 1;     end
        default: begin
          b = $urandom_range(255);
          l = $urandom_range(6000);
        end
      endcase
      program_reg(REG_BRIGHTNESS, b);
      program_reg(REG_CURRENT_LIMIT, l);
      // Run one phase back to back with no idling on either side.
      calm = (p == 2);
      repeat (228) pending_targets.push_back(random_word());
    end

    wait_idle();
    calm = 1'b0;
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
